// ===== hdl/sctl_pkg.sv =====
`default_nettype none
package sctl_pkg;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_PLACEMENT  = 2'd0;
    localparam logic [1:0] REG_LINES_LOG2 = 2'd1;
    localparam logic [1:0] REG_WAYS_LOG2  = 2'd2;

    // Placement codes; the unused code behaves as direct mapped
    localparam logic [1:0] PLACE_DIRECT = 2'd0;
    localparam logic [1:0] PLACE_FULL   = 2'd1;
    localparam logic [1:0] PLACE_SET    = 2'd2;

    localparam int LOG_W = 3;

    localparam logic [1:0]       PLACEMENT_RST  = PLACE_DIRECT;
    localparam logic [LOG_W-1:0] LINES_LOG2_RST = 3'd6;
    localparam logic [LOG_W-1:0] WAYS_LOG2_RST  = 3'd1;

    // Stream payload geometry
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 1;
    localparam int LINE_OUT_W  = 6;
    localparam int CNT_OUT_W   = 32;
    localparam int OUT_TDATA_W = 136;

    typedef struct packed {
        logic [1:0]       placement;
        logic [LOG_W-1:0] lines_log2;
        logic [LOG_W-1:0] ways_log2;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/sctl_cfg.sv =====
`default_nettype none
module sctl_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sctl_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [sctl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [sctl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output sctl_pkg::t_cfg                      o_cfg
);
    import sctl_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.placement  <= PLACEMENT_RST;
            r_cfg.lines_log2 <= LINES_LOG2_RST;
            r_cfg.ways_log2  <= WAYS_LOG2_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_PLACEMENT:  r_cfg.placement  <= pwdata[1:0];
                REG_LINES_LOG2: r_cfg.lines_log2 <= pwdata[LOG_W-1:0];
                REG_WAYS_LOG2:  r_cfg.ways_log2  <= pwdata[LOG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            REG_PLACEMENT:  prdata = CFG_DATA_W'(r_cfg.placement);
            REG_LINES_LOG2: prdata = CFG_DATA_W'(r_cfg.lines_log2);
            REG_WAYS_LOG2:  prdata = CFG_DATA_W'(r_cfg.ways_log2);
            default:        prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/sctl_tag_ram.sv =====
`default_nettype none
module sctl_tag_ram #(
    parameter int DEPTH_W = 7,
    parameter int DATA_W  = 33
) (
    input  wire logic              i_clk,
    input  wire logic [DEPTH_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0]  o_rd_data,
    input  wire logic              i_wr_en,
    input  wire logic [DEPTH_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]  i_wr_data
);

    logic [DATA_W-1:0] r_mem [2**DEPTH_W];
    logic [DATA_W-1:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ===== hdl/sctl_ctrl.sv =====
`default_nettype none
module sctl_ctrl #(
    parameter int ADDRESS_BITS = 32,
    parameter int LINE_W       = 6
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire sctl_pkg::t_cfg                  i_cfg,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_in_store,
    input  wire logic [ADDRESS_BITS-1:0]         i_in_addr,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [sctl_pkg::OUT_TDATA_W-1:0] o_out_data,
    output logic      [LINE_W:0]                 o_ram_rd_addr,
    input  wire logic [ADDRESS_BITS:0]           i_ram_rd_data,
    output logic                                 o_ram_wr_en,
    output logic      [LINE_W:0]                 o_ram_wr_addr,
    output logic      [ADDRESS_BITS:0]           o_ram_wr_data
);
    import sctl_pkg::*;

    localparam int CNT_W = LINE_W + 1;
    localparam logic [LOG_W-1:0] MAXL = LOG_W'(LINE_W);

    t_state                  r_state, n_state;
    logic [LINE_W:0]         r_clr, n_clr;
    logic                    r_store, n_store;
    logic [ADDRESS_BITS-1:0] r_addr, n_addr;
    logic [ADDRESS_BITS-1:0] r_mask, n_mask;
    logic [LOG_W-1:0]        r_bits, n_bits;
    logic [LINE_W-1:0]       r_rd_idx, n_rd_idx;
    logic [LINE_W-1:0]       r_cmp_idx, n_cmp_idx;
    logic                    r_cmp_vld, n_cmp_vld;
    logic [CNT_W-1:0]        r_left, n_left;
    logic [LINE_W-1:0]       r_victim, n_victim;
    logic [LINE_W-1:0]       r_line, n_line;
    logic                    r_hit, n_hit;
    logic [CNT_OUT_W-1:0]    r_acc, n_acc;
    logic [CNT_OUT_W-1:0]    r_hits, n_hits;
    logic [CNT_OUT_W-1:0]    r_misses, n_misses;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data, n_out_data;

    logic [LOG_W-1:0]        w_llog, w_wlog, w_bits;
    logic [LINE_W-1:0]       w_lmask, w_wmask, w_set, w_start, w_victim;
    logic [CNT_W-1:0]        w_count;
    logic                    w_match;
    logic [CNT_OUT_W-1:0]    w_acc1, w_hits1, w_misses1;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_ram_rd_addr = {r_store, r_rd_idx};

    // Clamp the geometry and work out the search window for a new access
    always_comb begin
        w_llog  = (i_cfg.lines_log2 > MAXL) ? MAXL : i_cfg.lines_log2;
        w_wlog  = (i_cfg.ways_log2 > w_llog) ? w_llog : i_cfg.ways_log2;
        w_lmask = ~({LINE_W{1'b1}} << w_llog);
        w_wmask = ~({LINE_W{1'b1}} << w_wlog);
        w_bits  = '0;
        w_set   = '0;
        w_start = '0;
        w_count = CNT_W'(1);
        w_victim = '0;
        case (i_cfg.placement)
            PLACE_FULL: begin
                w_bits   = '0;
                w_start  = '0;
                w_count  = CNT_W'(1) << w_llog;
                w_victim = r_acc[LINE_W-1:0] & w_lmask;
            end
            PLACE_SET: begin
                w_bits   = w_llog - w_wlog;
                w_set    = i_in_addr[LINE_W-1:0] & ~({LINE_W{1'b1}} << w_bits);
                w_start  = w_set << w_wlog;
                w_count  = CNT_W'(1) << w_wlog;
                w_victim = w_start | (r_acc[LINE_W-1:0] & w_wmask);
            end
            default: begin
                w_bits   = w_llog;
                w_start  = i_in_addr[LINE_W-1:0] & w_lmask;
                w_count  = CNT_W'(1);
                w_victim = w_start;
            end
        endcase
    end

    // Shared tag comparator: valid bit and address above the index bits
    assign w_match = r_cmp_vld & i_ram_rd_data[ADDRESS_BITS]
                   & (((i_ram_rd_data[ADDRESS_BITS-1:0] ^ r_addr) & r_mask) == '0);

    assign w_acc1    = r_acc + 1'b1;
    assign w_hits1   = r_hits + CNT_OUT_W'(r_hit);
    assign w_misses1 = r_misses + CNT_OUT_W'(!r_hit);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_store     = r_store;
        n_addr      = r_addr;
        n_mask      = r_mask;
        n_bits      = r_bits;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_vld   = r_cmp_vld;
        n_left      = r_left;
        n_victim    = r_victim;
        n_line      = r_line;
        n_hit       = r_hit;
        n_acc       = r_acc;
        n_hits      = r_hits;
        n_misses    = r_misses;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        o_ram_wr_en   = 1'b0;
        o_ram_wr_addr = {r_store, r_line};
        o_ram_wr_data = {1'b1, r_addr};

        // Drop the result once the beat is taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                o_ram_wr_en   = 1'b1;
                o_ram_wr_addr = r_clr;
                o_ram_wr_data = '0;
                n_clr         = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_store   = i_in_store;
                    n_addr    = i_in_addr;
                    n_bits    = w_bits;
                    n_mask    = {ADDRESS_BITS{1'b1}} << w_bits;
                    n_rd_idx  = w_start;
                    n_left    = w_count;
                    n_victim  = w_victim;
                    n_cmp_vld = 1'b0;
                    n_hit     = 1'b0;
                    n_state   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle, compare the line from the previous read
                n_cmp_idx = r_rd_idx;
                n_cmp_vld = (r_left != '0);
                if (r_left != '0) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                    n_left   = r_left - 1'b1;
                end
                if (w_match) begin
                    n_hit     = 1'b1;
                    n_line    = r_cmp_idx;
                    n_cmp_vld = 1'b0;
                    n_state   = ST_DONE;
                end else if (r_cmp_vld && (r_left == '0)) begin
                    n_hit     = 1'b0;
                    n_line    = r_victim;
                    n_cmp_vld = 1'b0;
                    n_state   = ST_FILL;
                end
            end
            ST_FILL: begin
                o_ram_wr_en = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_acc       = w_acc1;
                    n_hits      = w_hits1;
                    n_misses    = w_misses1;
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, w_acc1, w_misses1, w_hits1,
                                   CNT_OUT_W'(r_addr >> r_bits),
                                   LINE_OUT_W'(r_line), r_hit};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_cmp_vld   <= 1'b0;
            r_left      <= '0;
            r_acc       <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cmp_vld   <= n_cmp_vld;
            r_left      <= n_left;
            r_acc       <= n_acc;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_store    <= n_store;
        r_addr     <= n_addr;
        r_mask     <= n_mask;
        r_bits     <= n_bits;
        r_rd_idx   <= n_rd_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_victim   <= n_victim;
        r_line     <= n_line;
        r_hit      <= n_hit;
        r_out_data <= n_out_data;
    end

endmodule
`default_nettype wire

// ===== hdl/split_cache_tag_lookup.sv =====
// Search: an access reads and compares up to N tag lines, where N is 1 (direct mapped),
//   2^ways_log2 (set associative) or 2^lines_log2 (fully associative); a miss then fills a line.
// Throughput: one tag RAM read port and one comparator cover a line per cycle; a new access is
//   taken only once the result of the last one has gone into the output register.
// Reset: synchronous, active low; after release a clearing pass over all 2 * lines tag RAM entries
//   (128 with default parameters) wipes the tag RAM while s_axis_tready stays low.
`default_nettype none
module split_cache_tag_lookup #(
    parameter int ADDRESS_BITS = 32,
    parameter int MAX_LINES    = 64
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // address[31:0]
    input  wire logic [sctl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // mode[0]
    input  wire logic [sctl_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // hit[0], line_index[6:1], tag_value[38:7], hits_so_far[70:39],
    // misses_so_far[102:71], accesses_so_far[134:103], zero[135]
    output logic      [sctl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [sctl_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [sctl_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [sctl_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                    pready
);
    import sctl_pkg::*;

    // Lines per store actually reachable: lines_log2 tops out at 7
    localparam int MAXL_RAW = $clog2(MAX_LINES + 1) - 1;
    localparam int LINE_W   = (MAXL_RAW > 7) ? 7 : MAXL_RAW;

    t_cfg                w_cfg;
    logic [LINE_W:0]     w_rd_addr, w_wr_addr;
    logic [ADDRESS_BITS:0] w_rd_data, w_wr_data;
    logic                w_wr_en;

    sctl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sctl_tag_ram #(
        .DEPTH_W (LINE_W + 1),
        .DATA_W  (ADDRESS_BITS + 1)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    sctl_ctrl #(
        .ADDRESS_BITS (ADDRESS_BITS),
        .LINE_W       (LINE_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_in_store    (s_axis_tuser[0]),
        .i_in_addr     (s_axis_tdata[ADDRESS_BITS-1:0]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata),
        .o_ram_rd_addr (w_rd_addr),
        .i_ram_rd_data (w_rd_data),
        .o_ram_wr_en   (w_wr_en),
        .o_ram_wr_addr (w_wr_addr),
        .o_ram_wr_data (w_wr_data)
    );

endmodule
`default_nettype wire

// ===== hdl/sctl_checker.sv =====
`default_nettype none
module sctl_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [sctl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import sctl_pkg::*;

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

    // Access count is always hits plus misses
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[134:103] ==
                           CNT_OUT_W'(m_axis_tdata[70:39] + m_axis_tdata[102:71])))
        else $error("access count differs from hits plus misses");

    // One access at a time: busy right after an input beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a lookup is in flight");

    // Reset empties the output register and blocks input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && !s_axis_tready))
        else $error("block not idle after reset");

endmodule

bind split_cache_tag_lookup sctl_checker u_sctl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== tb/split_cache_tag_lookup_tb.sv =====
`timescale 1ns / 1ps
module split_cache_tag_lookup_tb;
    import sctl_pkg::*;

    localparam int MAX_LINES      = 64;
    localparam int LINES_LOG2_MAX = $clog2(MAX_LINES);
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int MAX_REPORTS    = 10;

    // The fourth placement code has no package name; it behaves as direct mapped
    localparam logic [1:0] PLACE_UNUSED = 2'd3;

    typedef enum int {
        PACE_NONE,
        PACE_SENDER,
        PACE_RECEIVER,
        PACE_BOTH
    } t_pace;

    typedef struct {
        logic        mode;
        logic [31:0] addr;
    } t_access;

    typedef struct packed {
        logic        hit;
        logic [5:0]  line;
        logic [31:0] tag;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] accesses;
    } t_lookup;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]    s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]    paddr = '0;
    logic [CFG_DATA_W-1:0]    pwdata = '0;
    logic [CFG_DATA_W-1:0]    prdata;
    logic                     pready;

    // Shadow tag stores and counters, indexed [store][line]
    logic [31:0]      tag_addr [2][MAX_LINES];
    bit               tag_valid [2][MAX_LINES];
    logic [31:0]      access_count = '0;
    logic [31:0]      hit_count = '0;
    logic [31:0]      miss_count = '0;
    logic [1:0]       cfg_placement = PLACEMENT_RST;
    logic [LOG_W-1:0] cfg_lines_log2 = LINES_LOG2_RST;
    logic [LOG_W-1:0] cfg_ways_log2 = WAYS_LOG2_RST;

    t_access     pending_accesses[$];
    t_lookup     expected_lookups[$];
    logic [31:0] hot_addresses[$];
    t_access     offered;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 1'b0;
    int hold_count = 0;
    int quiet_cycles = 0;
    int mismatch_count = 0;
    int results_checked = 0;
    int hits_seen = 0;
    int settings_run = 0;

    split_cache_tag_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void check_value(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
        end
    endfunction

    // Look up one block address in the shadow store, then fill on a miss
    function automatic t_lookup predict_lookup(input logic mode, input logic [31:0] addr);
        t_lookup     r;
        int          llog;
        int          wlog;
        int          nlines;
        int          ways;
        int          bits;
        int          set_base;
        int          i;
        logic [31:0] line;
        logic        found;
        llog   = (cfg_lines_log2 > LINES_LOG2_MAX) ? LINES_LOG2_MAX : cfg_lines_log2;
        wlog   = (cfg_ways_log2 > llog) ? llog : cfg_ways_log2;
        nlines = 1 << llog;
        found  = 1'b0;
        line   = '0;
        if (cfg_placement == PLACE_FULL) begin
            r.tag = addr;
            for (i = 0; i < nlines && !found; i++) begin
                if (tag_valid[mode][i] && tag_addr[mode][i] == addr) begin
                    found = 1'b1;
                    line  = i;
                end
            end
            if (!found)
                line = access_count & (nlines - 1);
        end else if (cfg_placement == PLACE_SET) begin
            ways     = 1 << wlog;
            bits     = llog - wlog;
            set_base = int'(addr & ((32'd1 << bits) - 1)) * ways;
            r.tag    = addr >> bits;
            for (i = set_base; i < set_base + ways && !found; i++) begin
                if (tag_valid[mode][i] && (tag_addr[mode][i] >> bits) == r.tag) begin
                    found = 1'b1;
                    line  = i;
                end
            end
            if (!found)
                line = set_base + (access_count & (ways - 1));
        end else begin
            // Direct mapped, also for the unused placement code
            bits  = llog;
            line  = addr & ((32'd1 << bits) - 1);
            r.tag = addr >> bits;
            found = tag_valid[mode][line[5:0]] && ((tag_addr[mode][line[5:0]] >> bits) == r.tag);
        end
        if (found) begin
            hit_count++;
        end else begin
            miss_count++;
            tag_addr[mode][line[5:0]]  = addr;
            tag_valid[mode][line[5:0]] = 1'b1;
        end
        access_count++;
        r.hit      = found;
        r.line     = line[5:0];
        r.hits     = hit_count;
        r.misses   = miss_count;
        r.accesses = access_count;
        return r;
    endfunction

    // Offer pending accesses; predict each one at the beat that takes it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_lookups.push_back(predict_lookup(offered.mode, offered.addr));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pending_accesses.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= offered.addr;
                    s_axis_tuser  <= offered.mode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Stall the result side; hold off once for a long stretch under pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_request && hold_count < HOLD_CYCLES) begin
            hold_count++;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare every result beat with the oldest predicted lookup
    always @(posedge i_clk) begin : check_results
        t_lookup want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_lookups.size() == 0) begin
                check_value("result beat with no lookup outstanding", 32'd0, 32'd1);
            end else begin
                want = expected_lookups.pop_front();
                results_checked++;
                if (want.hit)
                    hits_seen++;
                check_value("hit", want.hit, m_axis_tdata[0]);
                check_value("line_index", want.line, m_axis_tdata[6:1]);
                check_value("tag_value", want.tag, m_axis_tdata[38:7]);
                check_value("hits_so_far", want.hits, m_axis_tdata[70:39]);
                check_value("misses_so_far", want.misses, m_axis_tdata[102:71]);
                check_value("accesses_so_far", want.accesses, m_axis_tdata[134:103]);
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL split_cache_tag_lookup");
                $finish;
            end
        end
    end

    // Write one register, read it back, and track it in the shadow config
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_value("register read-back", value, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PLACEMENT:  cfg_placement  = value[1:0];
            REG_LINES_LOG2: cfg_lines_log2 = value[LOG_W-1:0];
            REG_WAYS_LOG2:  cfg_ways_log2  = value[LOG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_access(input logic mode, input logic [31:0] addr);
        t_access a;
        a.mode = mode;
        a.addr = addr;
        pending_accesses.push_back(a);
    endtask

    // Sample on the falling edge so the driver and monitor have settled
    task automatic wait_drained();
        while (pending_accesses.size() != 0 || s_axis_tvalid || expected_lookups.size() != 0)
            @(negedge i_clk);
    endtask

    // One register setting: reuse a small pool of addresses so lines hit,
    // with conflicting neighbors and fully random addresses mixed in
    task automatic run_phase(input logic [1:0] place, input logic [2:0] lines,
                             input logic [2:0] ways, input t_pace pace, input int count,
                             input bit pressure);
        int          eff;
        int          pool_size;
        int          n;
        int          pick;
        logic [31:0] a;
        write_reg(REG_PLACEMENT, place);
        write_reg(REG_LINES_LOG2, lines);
        write_reg(REG_WAYS_LOG2, ways);
        settings_run++;
        case (pace)
            PACE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PACE_SENDER:   begin send_idle_pct = 81; recv_stall_pct = 0;  end
            PACE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default:       begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
        hold_request = pressure;
        eff = (lines > LINES_LOG2_MAX) ? LINES_LOG2_MAX : lines;
        pool_size = (1 << eff) + (1 << eff) / 2 + 2;
        if (pool_size > 40)
            pool_size = 40;
        hot_addresses.delete();
        for (n = 0; n < pool_size; n++)
            hot_addresses.push_back($urandom);
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 65)
                a = hot_addresses[$urandom_range(pool_size - 1)];
            else if (pick < 85)
                a = hot_addresses[$urandom_range(pool_size - 1)] ^ (32'd1 << $urandom_range(31));
            else
                a = $urandom;
            queue_access($urandom_range(1), a);
        end
        wait_drained();
        hold_request = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset setting, direct mapped over 64 lines
        queue_access(1'b0, 32'h0000_0000);
        queue_access(1'b0, 32'h0000_0000);
        queue_access(1'b1, 32'h0000_0000);
        queue_access(1'b0, 32'hFFFF_FFFF);
        queue_access(1'b1, 32'hFFFF_FFFF);
        queue_access(1'b0, 32'hFFFF_FFFF);
        queue_access(1'b0, 32'hFFFF_FFBF);
        queue_access(1'b0, 32'hFFFF_FFFF);
        queue_access(1'b0, 32'h0000_0040);
        queue_access(1'b0, 32'h0000_0000);
        queue_access(1'b1, 32'h1234_5678);
        queue_access(1'b1, 32'h1234_5678);
        queue_access(1'b0, 32'h8000_0000);
        queue_access(1'b1, 32'h7FFF_FFFF);
        wait_drained();

        // Random: every placement code, clamped and zero-width index cases
        run_phase(PLACE_FULL,   3'd6, 3'd0, PACE_NONE,     110, 1'b0);
        run_phase(PLACE_SET,    3'd6, 3'd6, PACE_SENDER,   110, 1'b0);
        run_phase(PLACE_SET,    3'd7, 3'd7, PACE_RECEIVER, 110, 1'b0);
        run_phase(PLACE_SET,    3'd3, 3'd1, PACE_BOTH,     130, 1'b0);
        run_phase(PLACE_SET,    3'd2, 3'd5, PACE_NONE,     110, 1'b1);
        run_phase(PLACE_DIRECT, 3'd0, 3'd0, PACE_SENDER,   110, 1'b0);
        run_phase(PLACE_UNUSED, 3'd4, 3'd2, PACE_RECEIVER, 110, 1'b0);
        run_phase(PLACE_FULL,   3'd0, 3'd3, PACE_BOTH,     110, 1'b0);
        run_phase(PLACE_FULL,   3'd2, 3'd0, PACE_NONE,     130, 1'b0);
        run_phase(PLACE_DIRECT, 3'd7, 3'd4, PACE_SENDER,   130, 1'b0);
        run_phase(PLACE_DIRECT, 3'd2, 3'd7, PACE_RECEIVER, 110, 1'b0);
        run_phase(PLACE_SET,    3'd4, 3'd2, PACE_BOTH,     160, 1'b0);

        // Catch stray result beats after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        check_value("lookups left outstanding", 32'd0, expected_lookups.size());

        $display("Checked %0d lookups (%0d hits) over %0d register settings plus reset,",
                 results_checked, hits_seen, settings_run);
        $display("covering all placement codes, clamped sizes and a long result hold-off.");
        if (mismatch_count == 0) begin
            $display("PASS split_cache_tag_lookup");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAIL split_cache_tag_lookup");
        end
        $finish;
    end

endmodule
